// ===== design/vertex_dedup_table_macros.svh =====
// Assertion macros used by the vertex deduplication table checker.
`ifndef VERTEX_DEDUP_TABLE_MACROS_SVH
`define VERTEX_DEDUP_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VDT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/vdt_pkg.sv =====
// Types, constants and compare functions of the vertex deduplication table.
package vdt_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W       = 10;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] nrm_x;
        logic [31:0] nrm_y;
        logic [31:0] nrm_z;
        logic [31:0] tex_s;
        logic [31:0] tex_t;
    } t_corner;

    localparam int CORNER_W = $bits(t_corner);

    typedef struct packed {
        logic [IDX_W-1:0] vertex_index;
        logic             is_new;
        logic             table_full;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    // IEEE single equality on bit patterns: signed zeros match, NaN matches nothing.
    function automatic logic ieee_eq(logic [31:0] a, logic [31:0] b);
        logic nan_a;
        logic nan_b;
        logic both_zero;
        nan_a     = (a[30:0] > 31'h7F80_0000);
        nan_b     = (b[30:0] > 31'h7F80_0000);
        both_zero = ((a[30:0] | b[30:0]) == 31'h0);
        return !nan_a && !nan_b && (both_zero || (a == b));
    endfunction

    function automatic logic corner_eq(t_corner a, t_corner b);
        return ieee_eq(a.pos_x, b.pos_x) && ieee_eq(a.pos_y, b.pos_y) &&
               ieee_eq(a.pos_z, b.pos_z) && ieee_eq(a.nrm_x, b.nrm_x) &&
               ieee_eq(a.nrm_y, b.nrm_y) && ieee_eq(a.nrm_z, b.nrm_z) &&
               ieee_eq(a.tex_s, b.tex_s) && ieee_eq(a.tex_t, b.tex_t);
    endfunction

endpackage

// ===== design/vdt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module vdt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/vertex_dedup_table.sv =====
// Vertex deduplication table: linear search over a single vertex RAM, append on miss unless full.
// Throughput: one transaction at a time; a corner holds the block while stored vertices are read
// (one RAM read a cycle) and while a stalled result blocks output.
// A result is registered in r_res at the end of the search, then moved to the output register;
// the next corner can be taken the cycle after that load.
// Reset (synchronous, active low) empties the table; the RAM contents are not cleared.
module vertex_dedup_table (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  vdt_pkg::t_corner i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output vdt_pkg::t_result o_data
);

    import vdt_pkg::*;

    t_state              r_state;
    t_state              n_state;
    t_corner             r_item;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_addr;
    logic                r_rd_pend;
    logic [ADDR_W-1:0]   r_rd_addr;
    t_result             r_res;
    t_result             n_res;
    logic                r_out_valid;
    t_result             r_out;

    logic [CORNER_W-1:0] ram_rd_data;
    t_corner             rd_corner;
    logic                hit;
    logic                scan_end;
    logic                full;
    logic                rd_en;
    logic                wr_en;
    logic                accept;
    logic                decide;
    logic                load_out;

    assign rd_corner = t_corner'(ram_rd_data);
    // A read issued last cycle is compared now; reads stop once the stored count is reached.
    assign hit       = r_rd_pend && corner_eq(rd_corner, r_item);
    assign scan_end  = (r_addr == r_count);
    assign full      = (r_count == CNT_W'(TABLE_DEPTH));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit || scan_end) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall  = 1'b1;
        accept   = 1'b0;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        decide   = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                accept  = i_valid;
            end
            ST_SCAN: begin
                rd_en  = !hit && !scan_end;
                decide = hit || scan_end;
                wr_en  = !hit && scan_end && !full;
            end
            ST_EMIT: begin
                load_out = !r_out_valid || !i_stall;
            end
            default: o_stall = 1'b1;
        endcase
    end

    always_comb begin
        if (hit) begin
            n_res.vertex_index = IDX_W'(r_rd_addr);
            n_res.is_new       = 1'b0;
            n_res.table_full   = 1'b0;
        end else if (full) begin
            n_res.vertex_index = '0;
            n_res.is_new       = 1'b0;
            n_res.table_full   = 1'b1;
        end else begin
            n_res.vertex_index = IDX_W'(r_count[ADDR_W-1:0]);
            n_res.is_new       = 1'b1;
            n_res.table_full   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_addr      <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= rd_en;
            if (accept) begin
                r_addr <= '0;
            end else if (rd_en) begin
                r_addr <= r_addr + CNT_W'(1);
            end
            if (wr_en) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_data;
        end
        if (rd_en) begin
            r_rd_addr <= r_addr[ADDR_W-1:0];
        end
        if (decide) begin
            r_res <= n_res;
        end
        if (load_out) begin
            r_out <= r_res;
        end
    end

    vdt_ram #(
        .WIDTH (CORNER_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (r_item),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr[ADDR_W-1:0]),
        .o_rd_data (ram_rd_data)
    );

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== design/vdt_checker.sv =====
// Port-level checks for the vertex deduplication table, bound to the top level.
`include "vertex_dedup_table_macros.svh"

module vdt_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input vdt_pkg::t_corner i_data,
    input logic             o_valid,
    input logic             i_stall,
    input vdt_pkg::t_result o_data
);

    import vdt_pkg::*;

    `VDT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
                     o_valid && $stable(o_data), "stalled result transaction changed")
    `VDT_ASSERT_NOW(a_flags_excl, i_clk, i_rst_n, o_valid,
                    !(o_data.is_new && o_data.table_full), "result flagged both new and full")
    `VDT_ASSERT_NOW(a_full_index, i_clk, i_rst_n, o_valid && o_data.table_full,
                    o_data.vertex_index == '0, "full result with non-zero index")
    `VDT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall,
                     o_stall, "input taken again while a search runs")

endmodule

bind vertex_dedup_table vdt_checker u_vdt_checker (.*);
